// ----- rtl/core/lyapunov_exponent_pixel_defines.svh -----
// assertion macros shared by the lyapunov exponent pixel block
// expects clk and rst_n in the scope of each use
`ifndef LYAPUNOV_EXPONENT_PIXEL_DEFINES_SVH
`define LYAPUNOV_EXPONENT_PIXEL_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define LEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lep assertion failed");
// next-cycle implication
`define LEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lep assertion failed");
`else
`define LEP_ASSERT_IMP(lbl, ante, cons)
`define LEP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/lep_pkg.sv -----
// shared types and constants of the lyapunov exponent pixel block
// no dependencies
package lep_pkg;

  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_PATTERN);
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned SUM_W       = 41;
  localparam int unsigned MAG_W       = SUM_W - 1;
  localparam int unsigned FRAC_W      = 16;

  // ln2 in q0.32, split in halves
  localparam logic [15:0] LN2_HI = 16'hB172;
  localparam logic [15:0] LN2_LO = 16'h17F8;
  localparam logic [7:0]  LOG_BIAS = 8'd61;

  // configuration register indexes
  localparam logic [1:0] CFG_PATTERN_BITS    = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_ITERATION_COUNT = 2'd2;
  localparam logic [1:0] CFG_START_VALUE     = 2'd3;

  // configuration reset values
  localparam logic [31:0]      RST_PATTERN_BITS    = 32'd2244;
  localparam logic [LEN_W-1:0] RST_PATTERN_LENGTH  = 6'd17;
  localparam logic [CNT_W-1:0] RST_ITERATION_COUNT = 16'd400;
  localparam logic [31:0]      RST_START_VALUE     = 32'd1349303704;

  // shared multiplier operands
  typedef struct packed {
    logic [32:0] op_a;
    logic [32:0] op_b;
  } mul_req_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_P,
    S_X,
    S_D,
    S_M,
    S_NORM,
    S_SQ0,
    S_SQ,
    S_ACC,
    S_FIN,
    S_WAIT,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/lep_in_if.sv -----
// input channel: one beat carries a pixel's two growth rates
// no dependencies
interface lep_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] rate_a;
  logic [31:0] rate_b;

  modport source(output valid, output rate_a, output rate_b, input ready);
  modport sink(input valid, input rate_a, input rate_b, output ready);
endinterface

// ----- rtl/core/lep_out_if.sv -----
// result channel: one beat carries the exponent level
// no dependencies
interface lep_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] exponent_level;

  modport source(output valid, output exponent_level, input ready);
  modport sink(input valid, input exponent_level, output ready);
endinterface

// ----- rtl/core/lyapunov_exponent_pixel.sv -----
// lyapunov exponent pixel: one beat in, one beat out after the map iterations
// sequence: each map step runs P, X, D, M, NORM, squaring rounds and ACC, with
// no squaring for a zero-derivative step; then FIN, WAIT and DONE; the divider
// ends early on saturation or count 0; not ready until the result is loaded
// reset: synchronous active-low rst_n restores config defaults, clears control
// depends on lep_pkg, lep_in_if, lep_out_if, lep_mul, lep_div, defines header
`include "lyapunov_exponent_pixel_defines.svh"
module lyapunov_exponent_pixel
  import lep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lep_in_if.sink      in_bus,
  lep_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]      pattern_bits_r;
  logic [LEN_W-1:0] pattern_length_r;
  logic [CNT_W-1:0] iteration_count_r;
  logic [31:0]      start_value_r;

  state_t state_r, state_nxt;

  logic [31:0]      ra_r, rb_r, x_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [31:0]      z_r;
  logic [5:0]       k_r;
  logic [FRAC_W-1:0] frac_r;
  logic [3:0]       sq_r;
  logic             skip_r;
  logic             out_valid_r;
  logic [7:0]       out_level_r;

  mul_req_t    mreq;
  logic [63:0] prod;
  logic [31:0] rate;
  logic [LEN_W-1:0] len;
  logic [31:0] xn;
  logic [32:0] x2, dval;
  logic [5:0]  kn;
  logic [63:0] zsh;
  logic [32:0] sqv;
  logic [31:0] zq;
  logic [7:0]  kb;
  logic [SUM_W-1:0] term;
  logic [MAG_W-1:0] mag;
  logic        in_fire, div_start, div_busy, div_done, out_load;
  logic [7:0]  div_level;

  // position of the leading one
  function automatic logic [5:0] msb_pos(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bits_r    <= RST_PATTERN_BITS;
      pattern_length_r  <= RST_PATTERN_LENGTH;
      iteration_count_r <= RST_ITERATION_COUNT;
      start_value_r     <= RST_START_VALUE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_BITS:    pattern_bits_r    <= cfg_data;
        CFG_PATTERN_LENGTH:  pattern_length_r  <= cfg_data[LEN_W-1:0];
        CFG_ITERATION_COUNT: iteration_count_r <= cfg_data[CNT_W-1:0];
        CFG_START_VALUE:     start_value_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped pattern length and rate of this step
  assign len  = (pattern_length_r == '0) ? LEN_W'(1) :
                (pattern_length_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) :
                pattern_length_r;
  assign rate = pattern_bits_r[idx_r] ? rb_r : ra_r;

  // map update with saturation
  assign xn = (prod[63:61] != 3'b000) ? 32'hFFFF_FFFF : prod[60:29];
  // |1 - 2x| in q1.32
  assign x2   = {x_r, 1'b0};
  assign dval = (x2 <= 33'h1_0000_0000) ? (33'h1_0000_0000 - x2) : (x2 - 33'h1_0000_0000);
  // normalize derivative magnitude to q1.31
  assign kn  = msb_pos(prod);
  assign zsh = (kn >= 6'd31) ? (prod >> (kn - 6'd31)) : (prod << (6'd31 - kn));
  // one log squaring round
  assign sqv = prod[63:31];
  assign zq  = sqv[32] ? sqv[32:1] : sqv[31:0];
  // log2 term in q.16
  assign kb   = {2'b00, k_r} - LOG_BIAS;
  assign term = {{(SUM_W - 24){kb[7]}}, kb, frac_r};
  assign mag  = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = (iteration_count_r == '0) ? S_FIN : S_P;
      end
      S_P:    state_nxt = S_X;
      S_X:    state_nxt = S_D;
      S_D:    state_nxt = S_M;
      S_M:    state_nxt = S_NORM;
      S_NORM: state_nxt = (prod == '0) ? S_ACC : S_SQ0;
      S_SQ0:  state_nxt = S_SQ;
      S_SQ: begin
        if (sq_r == 4'd15) state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = (cnt_r + CNT_W'(1) == iteration_count_r) ? S_FIN : S_P;
      end
      S_FIN:  state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: multiplier operands and divider start
  always_comb begin
    mreq      = '0;
    div_start = 1'b0;
    case (state_r)
      S_P: begin
        mreq.op_a = {1'b0, x_r};
        mreq.op_b = 33'h1_0000_0000 - {1'b0, x_r};
      end
      S_X: begin
        mreq.op_a = {1'b0, rate};
        mreq.op_b = {1'b0, prod[63:32]};
      end
      S_M: begin
        mreq.op_a = {1'b0, rate};
        mreq.op_b = dval;
      end
      S_SQ0: begin
        mreq.op_a = {1'b0, z_r};
        mreq.op_b = {1'b0, z_r};
      end
      S_SQ: begin
        mreq.op_a = {1'b0, zq};
        mreq.op_b = {1'b0, zq};
      end
      S_FIN: div_start = 1'b1;
      default: ;
    endcase
  end

  // state register and output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    if (out_load) out_level_r <= div_level;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ra_r  <= in_bus.rate_a;
          rb_r  <= in_bus.rate_b;
          x_r   <= start_value_r;
          idx_r <= '0;
          cnt_r <= '0;
          sum_r <= '0;
        end
      end
      S_D: x_r <= xn;
      S_NORM: begin
        skip_r <= (prod == '0);
        k_r    <= kn;
        z_r    <= zsh[31:0];
        frac_r <= '0;
        sq_r   <= '0;
      end
      S_SQ: begin
        frac_r <= {frac_r[FRAC_W-2:0], sqv[32]};
        sq_r   <= sq_r + 4'd1;
      end
      S_ACC: begin
        if (!skip_r) sum_r <= sum_r + $signed(term);
        cnt_r <= cnt_r + CNT_W'(1);
        if (LEN_W'(idx_r) + LEN_W'(1) >= len) begin
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  lep_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  lep_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (mag),
    .count (iteration_count_r),
    .busy  (div_busy),
    .done  (div_done),
    .level (div_level)
  );

  assign in_bus.ready           = (state_r == S_IDLE);
  assign out_bus.valid          = out_valid_r;
  assign out_bus.exponent_level = out_level_r;

  // checks
  `LEP_ASSERT_NXT(a_busy_after_in, in_fire, !in_bus.ready)
  `LEP_ASSERT_IMP(a_div_done_wait, div_done, state_r == S_WAIT)
  `LEP_ASSERT_IMP(a_load_div_idle, out_load, !div_busy)

endmodule

// ----- rtl/core/lep_mul.sv -----
// shared 33x33 multiplier with registered product
// depends on lep_pkg
module lep_mul
  import lep_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [63:0] prod
);

  logic [65:0] prod_r;

  // product register
  always_ff @(posedge clk) begin
    prod_r <= 66'(req.op_a) * 66'(req.op_b);
  end

  assign prod = prod_r[63:0];

endmodule

// ----- rtl/core/lep_div.sv -----
// final scaling: floor(mag*10*ln2 / (count*2^16)), saturated at 255
// depends on lep_pkg; restoring division, one quotient bit per cycle
module lep_div
  import lep_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  input  logic [CNT_W-1:0] count,
  output logic             busy,
  output logic             done,
  output logic [7:0]       level
);

  logic [43:0] a;
  logic [59:0] t1_nxt;
  logic [59:0] t2_nxt;
  logic [59:0] t1_r, t2_r;
  logic [60:0] rem_r;
  logic [54:0] dsh_r;
  logic [60:0] dsh_ext;
  logic [60:0] dtop_ext;
  logic [3:0]  ph_r;
  logic        busy_r, done_r, zero_r;
  logic [7:0]  q_r;

  // ten times magnitude, then constant products with ln2 halves
  assign a       = 44'({mag, 3'b000}) + 44'({mag, 1'b0});
  assign t1_nxt  = 60'(a) * 60'(LN2_HI);
  assign t2_nxt  = 60'((60'(a) * 60'(LN2_LO)) >> 16);
  assign dsh_ext = 61'(dsh_r);
  assign dtop_ext = 61'({dsh_r, 1'b0});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        ph_r <= ph_r + 4'd1;
        if ((ph_r == 4'd1 && (zero_r || rem_r >= dtop_ext)) || ph_r == 4'd9) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      t1_r   <= t1_nxt;
      t2_r   <= t2_nxt;
      zero_r <= (count == '0);
      dsh_r  <= {count, 39'b0};
      q_r    <= '0;
    end else if (busy_r) begin
      if (ph_r == 4'd0) begin
        rem_r <= 61'(t1_r) + 61'(t2_r);
      end else if (ph_r == 4'd1) begin
        if (zero_r) begin
          q_r <= '0;
        end else if (rem_r >= dtop_ext) begin
          q_r <= 8'hFF;
        end
      end else begin
        // one quotient bit
        if (rem_r >= dsh_ext) begin
          rem_r <= rem_r - dsh_ext;
          q_r   <= {q_r[6:0], 1'b1};
        end else begin
          q_r <= {q_r[6:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign level = q_r;

endmodule
